@@ design/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg: shared definitions of the set-associative LRU cache model
// Widths, reset values, register indexes, commands and state types.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    localparam int ADDR_W = 64;
    localparam int CMD_W  = 2;
    localparam int HIT_W  = 2;

    localparam int SETB_W = 3;
    localparam int WAYS_W = 4;
    localparam int BLKB_W = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int Q_DEPTH = 2;

    localparam logic [SETB_W-1:0] RST_SET_BITS   = 3'd4;
    localparam logic [WAYS_W-1:0] RST_WAYS       = 4'd1;
    localparam logic [BLKB_W-1:0] RST_BLOCK_BITS = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_WAYS       = 2'd1,
        CFG_BLOCK_BITS = 2'd2
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [SETB_W-1:0] set_bits;
        logic [WAYS_W-1:0] ways;
        logic [BLKB_W-1:0] block_bits;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

endpackage

@@ design/salc_front.sv @@
// ----------------------------------------------------------------------------
// salc_front: access intake and address split
// Accepts commands and splits the address into set index and tag.
// ----------------------------------------------------------------------------
module salc_front import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  t_cfg              i_cfg,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_busy,
    output logic              o_push,
    output logic [SET_W-1:0]  o_set_index,
    output logic [ADDR_W-1:0] o_tag
);

    localparam int SHIFT_W = $clog2(MAX_SET_BITS + 32);

    logic [SHIFT_W-1:0] s_eff;
    logic [SHIFT_W-1:0] shift;
    logic [ADDR_W-1:0]  off_shifted;
    logic [SET_W-1:0]   set_mask;

    assign o_busy = i_q_full | i_clearing;
    assign o_push = i_start & ~o_busy;

    assign s_eff = (i_cfg.set_bits > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                   : SHIFT_W'(i_cfg.set_bits);
    assign shift = s_eff + SHIFT_W'(i_cfg.block_bits);

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (SHIFT_W'(i) < s_eff);
        end
    end

    assign off_shifted = i_address >> i_cfg.block_bits;
    assign o_set_index = off_shifted[SET_W-1:0] & set_mask;
    assign o_tag       = i_address >> shift;

endmodule

@@ design/salc_queue.sv @@
// ----------------------------------------------------------------------------
// salc_queue: short access queue
// Two-entry FIFO between the intake and the lookup engine.
// ----------------------------------------------------------------------------
module salc_queue import salc_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

@@ design/salc_back.sv @@
// ----------------------------------------------------------------------------
// salc_back: set lookup and replacement engine
// Reads one set row, resolves hit, fill or eviction, writes the row back.
// ----------------------------------------------------------------------------
module salc_back import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_empty,
    input  logic [CMD_W-1:0]  i_q_command,
    input  logic [SET_W-1:0]  i_q_set,
    input  logic [ADDR_W-1:0] i_q_tag,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_result_valid,
    output logic [HIT_W-1:0]  o_hit_count,
    output logic              o_missed,
    output logic              o_evicted
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = RANK_W;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int RANK_LO  = MAX_WAYS;
    localparam int TAG_LO   = MAX_WAYS * (1 + RANK_W);
    localparam int ROW_W    = MAX_WAYS * (1 + RANK_W + ADDR_W);

    t_back_state r_state, n_state;

    logic [ROW_W-1:0]  r_mem [NUM_SETS];
    logic [ROW_W-1:0]  r_rd_row;
    logic [SET_W-1:0]  r_clr_idx;
    logic [CMD_W-1:0]  r_cmd;
    logic [SET_W-1:0]  r_set;
    logic [ADDR_W-1:0] r_tag;

    logic              r_res_valid;
    logic [HIT_W-1:0]  r_hit_count;
    logic              r_missed;
    logic              r_evicted;

    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              res_load;

    logic [ROW_W-1:0]  clr_row;
    logic [ROW_W-1:0]  new_row;

    logic [NW_W-1:0]   nways;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] v;
    logic [RANK_W-1:0] rk [MAX_WAYS];
    logic [ADDR_W-1:0] tg [MAX_WAYS];

    logic              hit;
    logic              have_free;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  fill_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  tgt;
    logic [RANK_W-1:0] old_rank;
    logic [HIT_W-1:0]  hits;

    assign o_clearing     = (r_state == BK_CLEAR);
    assign o_result_valid = r_res_valid;
    assign o_hit_count    = r_hit_count;
    assign o_missed       = r_missed;
    assign o_evicted      = r_evicted;

    // A cleared row has every line invalid and ranks equal to the way index.
    always_comb begin
        clr_row = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            clr_row[RANK_LO + w*RANK_W +: RANK_W] = RANK_W'(w);
        end
    end

    assign nways = (i_cfg.ways == '0)      ? NW_W'(1) :
                   (i_cfg.ways > MAX_WAYS) ? NW_W'(MAX_WAYS) : NW_W'(i_cfg.ways);

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (NW_W'(w) < nways);
            v[w]      = r_rd_row[w];
            rk[w]     = r_rd_row[RANK_LO + w*RANK_W +: RANK_W];
            tg[w]     = r_rd_row[TAG_LO + w*ADDR_W +: ADDR_W];
        end
    end

    // Lowest matching way and lowest free way: scan downward so the lowest wins.
    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        fill_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && v[w] && (tg[w] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !v[w]) begin
                have_free = 1'b1;
                fill_way  = WAY_W'(w);
            end
        end
    end

    // Oldest in-use way; a strict compare keeps the lowest way on ties.
    always_comb begin
        victim = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (rk[w] > rk[victim])) begin
                victim = WAY_W'(w);
            end
        end
    end

    assign tgt      = hit ? hit_way : (have_free ? fill_way : victim);
    assign old_rank = rk[tgt];
    assign hits     = HIT_W'(hit) + HIT_W'(r_cmd == CMD_MODIFY);

    always_comb begin
        new_row = r_rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == tgt) begin
                new_row[w] = 1'b1;
                new_row[RANK_LO + w*RANK_W +: RANK_W] = '0;
                if (!hit) begin
                    new_row[TAG_LO + w*ADDR_W +: ADDR_W] = r_tag;
                end
            end else if (in_use[w] && (rk[w] < old_rank)
                         && (rk[w] < RANK_W'(MAX_WAYS - 1))) begin
                new_row[RANK_LO + w*RANK_W +: RANK_W] = RANK_W'(rk[w] + 1'b1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = new_row;
        res_load  = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = clr_row;
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                mem_we   = 1'b1;
                res_load = 1'b1;
                n_state  = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_idx   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= res_load;
            if (r_state == BK_CLEAR) begin
                r_clr_idx <= SET_W'(r_clr_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_command;
            r_set <= i_q_set;
            r_tag <= i_q_tag;
        end
        if (res_load) begin
            r_hit_count <= hits;
            r_missed    <= ~hit;
            r_evicted   <= ~hit & ~have_free;
        end
    end

    // Set memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd_row <= r_mem[i_q_set];
        end
    end

endmodule

@@ design/set_assoc_lru_cache_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative cache with LRU replacement
// Looks up each access in its set and reports hits, misses and evictions.
// ----------------------------------------------------------------------------
// Usage:
//   An access (i_command, i_address) is taken on a clock edge where start is
//   high and busy is low. Accepted accesses wait in a two-entry queue; the
//   lookup engine pops one, reads the set row from the set memory, then in the
//   next cycle resolves hit, fill or eviction and writes the row back.
//   The result appears on o_hit_count, o_missed and o_evicted for exactly one
//   cycle with o_result_valid high; the receiver cannot stall it.
//   The result flags are registered in the write-back step. The engine pops a
//   new access only in its idle state, so it takes no new access until the
//   last one is written back; the set memory has one write and one read port.
//   Configuration registers (0 set_bits, 1 ways, 2 block_bits) are written
//   through i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data; o_cfg_ready is
//   always high. Writes are to be made only while no access is in flight,
//   which the block does not enforce. After reset the engine clears the whole
//   set memory, one set per cycle; busy is high meanwhile.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_result_valid,
    output logic [HIT_W-1:0]      o_hit_count,
    output logic                  o_missed,
    output logic                  o_evicted,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int Q_W   = CMD_W + SET_W + ADDR_W;

    t_cfg              r_cfg;
    logic              clearing;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;
    logic [SET_W-1:0]  fr_set;
    logic [ADDR_W-1:0] fr_tag;
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= RST_SET_BITS;
            r_cfg.ways       <= RST_WAYS;
            r_cfg.block_bits <= RST_BLOCK_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_cfg.set_bits   <= i_cfg_data[SETB_W-1:0];
                CFG_WAYS:       r_cfg.ways       <= i_cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: r_cfg.block_bits <= i_cfg_data[BLKB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    salc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .SET_W        (SET_W)
    ) u_front (
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_address   (i_address),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .o_busy      (busy),
        .o_push      (q_push),
        .o_set_index (fr_set),
        .o_tag       (fr_tag)
    );

    assign q_in = {i_command, fr_set, fr_tag};

    salc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .SET_W        (SET_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_command    (q_out[Q_W-1 -: CMD_W]),
        .i_q_set        (q_out[ADDR_W +: SET_W]),
        .i_q_tag        (q_out[ADDR_W-1:0]),
        .o_pop          (q_pop),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_hit_count    (o_hit_count),
        .o_missed       (o_missed),
        .o_evicted      (o_evicted)
    );

    // No results can come out while the set memory is being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_result_valid)
        else $error("result strobe during memory clear");

    // Every access passes through a read step and a write-back step, so strobes never touch.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("back-to-back result strobes");

    // An eviction only happens on a miss.
    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_evicted) |-> o_missed)
        else $error("eviction reported on a hit");

    // A hit always counts at least one hit.
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_missed) |-> (o_hit_count != '0))
        else $error("hit reported with zero hit count");

endmodule
